[rtl/core/kbs_pkg.sv]
package kbs_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 28;
    localparam int SINE_STEPS_DEF      = 30;

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] GAIN_Q40 = 64'd667681663043;

    localparam logic [6:0]  STEP_CAP      = 7'd64;
    localparam logic [6:0]  MAX_ITER_RST  = 7'd32;
    localparam logic [28:0] TOLERANCE_RST = 29'd268;

    localparam logic [1:0] CFG_MAX_ITER  = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE = 2'd1;

    localparam logic [1:0] STOP_EXACT = 2'd0;
    localparam logic [1:0] STOP_TOL   = 2'd1;
    localparam logic [1:0] STOP_LIMIT = 2'd2;

    typedef struct packed {
        logic [30:0] mean_anomaly;
        logic [30:0] eccentricity;
    } req_t;

    typedef struct packed {
        logic [30:0] eccentric_anomaly;
        logic [1:0]  stop_cause;
        logic [6:0]  steps_used;
    } rsp_t;

    // arctan(2^-i) in q62, alternating series with truncated terms
    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          sh;
        sum = '0;
        if (i == 0)
        begin
            return PI_Q60;
        end
        for (int k = 0; k < 64; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh > 62)
            begin
                break;
            end
            term = (64'd1 << (62 - sh)) / 64'(2 * k + 1);
            if ((k % 2) == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

endpackage

[rtl/core/kepler_bisection_solver_core.sv]
// channel | direction | handshake              | payload
// in      | request   | in_valid / in_ready    | kbs_pkg::req_t
// out     | result    | out_valid / out_ready  | kbs_pkg::rsp_t
// cfg     | write     | cfg_write              | cfg_index, cfg_data
//
// each bisection step evaluates f at mid, low and high end; each evaluation runs
// setup, cordic rotations, multiply and f on the shared cordic/multiply datapath,
// and a solve ends early when f(mid) is zero or when the step limit ends it
// in_ready is high only while idle; a result waiting on out_ready holds the solver
// in its final state, the previous result stays in the output register meanwhile
// reset loads max_iterations 32 and tolerance 268, no clearing pass
module kepler_bisection_solver_core #(
    parameter int ANGLE_FRAC_BITS = kbs_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int SINE_STEPS      = kbs_pkg::SINE_STEPS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  kbs_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output kbs_pkg::rsp_t out_data,
    input  logic          cfg_write,
    input  logic [1:0]    cfg_index,
    input  logic [28:0]   cfg_data
);

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int AW  = (F + 3 > 31) ? F + 3 : 31;
    localparam int W   = AW + 1;
    localparam int MGW = F + 2;
    localparam int FW  = AW + 2;
    localparam int IW  = (SINE_STEPS > 1) ? $clog2(SINE_STEPS) : 1;

    localparam logic [AW-1:0] PI_A      = AW'(kbs_pkg::PI_Q60 >> (60 - F));
    localparam logic [AW-1:0] HALF_PI_A = AW'(kbs_pkg::PI_Q60 >> (61 - F));
    localparam logic [AW-1:0] TWO_PI_A  = AW'(kbs_pkg::PI_Q60 >> (59 - F));
    localparam logic [AW-1:0] UPPER_A   = PI_A + HALF_PI_A;
    localparam logic signed [W-1:0] X0  = W'(kbs_pkg::GAIN_Q40 >> (40 - F));
    localparam logic [IW-1:0] LAST_IT   = IW'(SINE_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_SETUP,
        S_ROT,
        S_MUL,
        S_FVAL,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        EV_MID,
        EV_LO,
        EV_HI
    } eval_t;

    logic signed [W-1:0] atan_tab [SINE_STEPS];

    for (genvar gi = 0; gi < SINE_STEPS; gi++)
    begin : g_atan
        localparam logic [63:0] AQ = kbs_pkg::atan_q62(gi);
        assign atan_tab[gi] = W'(AQ >> (62 - F));
    end

    state_t               state_reg;
    eval_t                ev_reg;
    logic [6:0]           max_iter_reg;
    logic [28:0]          tol_reg;
    logic [6:0]           lim_reg;
    logic [6:0]           steps_reg;
    logic [AW-1:0]        ma_reg;
    logic [30:0]          ecc_reg;
    logic [AW-1:0]        lo_reg;
    logic [AW-1:0]        hi_reg;
    logic [AW-1:0]        mid_reg;
    logic [AW-1:0]        saved_reg;
    logic [AW-1:0]        ang_reg;
    logic                 have_saved_reg;
    logic                 exact_reg;
    logic [1:0]           cause_reg;
    logic                 zero_sin_reg;
    logic signed [W-1:0]  x_reg;
    logic signed [W-1:0]  y_reg;
    logic signed [W-1:0]  th_reg;
    logic [IW-1:0]        it_reg;
    logic [MGW-1:0]       prod_reg;
    logic                 neg_reg;
    logic                 sf_neg_reg;
    logic                 sa_neg_reg;
    logic                 sa_zero_reg;
    logic                 out_valid_reg;
    kbs_pkg::rsp_t        out_data_reg;

    logic [AW:0]          mid_sum;
    logic [AW-1:0]        ma_in;
    logic signed [W-1:0]  xs;
    logic signed [W-1:0]  ys;
    logic [MGW-1:0]       mag;
    logic [MGW+30:0]      prod_full;
    logic signed [FW-1:0] p_s;
    logic signed [FW-1:0] f_val;
    logic                 f_neg;
    logic                 f_zero;
    logic [AW-1:0]        lo_next;
    logic [AW-1:0]        hi_next;
    logic [AW-1:0]        width_next;
    logic [AW-1:0]        result;
    logic [1:0]           cause_fin;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign ma_in   = (in_data.mean_anomaly > 31'(TWO_PI_A)) ? TWO_PI_A : AW'(in_data.mean_anomaly);
    assign xs      = x_reg >>> it_reg;
    assign ys      = y_reg >>> it_reg;
    assign mag     = zero_sin_reg ? '0 : MGW'((y_reg < 0) ? -y_reg : y_reg);
    assign prod_full = ecc_reg * mag;
    assign p_s     = neg_reg ? -FW'(prod_reg) : FW'(prod_reg);
    assign f_val   = FW'(ang_reg) - p_s - FW'(ma_reg);
    assign f_neg   = f_val < 0;
    assign f_zero  = f_val == '0;

    // halve the bracket: keep the end whose sign differs from f(mid)
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (!sa_zero_reg && (sa_neg_reg != sf_neg_reg))
        begin
            hi_next = mid_reg;
        end
        else
        begin
            lo_next = mid_reg;
        end
        width_next = hi_next - lo_next;
    end

    always_comb
    begin
        result    = mid_reg;
        cause_fin = cause_reg;
        if (!exact_reg)
        begin
            priority if (have_saved_reg)
            begin
                result = saved_reg;
            end
            else if (ma_reg == '0)
            begin
                result    = '0;
                cause_fin = kbs_pkg::STOP_EXACT;
            end
            else if (ma_reg == TWO_PI_A)
            begin
                result    = TWO_PI_A;
                cause_fin = kbs_pkg::STOP_EXACT;
            end
            else
            begin
                result    = TWO_PI_A >> 1;
                cause_fin = kbs_pkg::STOP_LIMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= kbs_pkg::MAX_ITER_RST;
            tol_reg      <= kbs_pkg::TOLERANCE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                kbs_pkg::CFG_MAX_ITER:  max_iter_reg <= cfg_data[6:0];
                kbs_pkg::CFG_TOLERANCE: tol_reg      <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            ev_reg         <= EV_MID;
            steps_reg      <= '0;
            have_saved_reg <= 1'b0;
            exact_reg      <= 1'b0;
            cause_reg      <= kbs_pkg::STOP_LIMIT;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ma_reg         <= ma_in;
                        ecc_reg        <= in_data.eccentricity;
                        lim_reg        <= (max_iter_reg > kbs_pkg::STEP_CAP) ?
                                          kbs_pkg::STEP_CAP : max_iter_reg;
                        lo_reg         <= '0;
                        hi_reg         <= TWO_PI_A;
                        steps_reg      <= '0;
                        have_saved_reg <= 1'b0;
                        exact_reg      <= 1'b0;
                        cause_reg      <= kbs_pkg::STOP_LIMIT;
                        state_reg      <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (steps_reg < lim_reg)
                    begin
                        mid_reg   <= mid_sum[AW:1];
                        ang_reg   <= mid_sum[AW:1];
                        steps_reg <= steps_reg + 7'd1;
                        ev_reg    <= EV_MID;
                        state_reg <= S_SETUP;
                    end
                    else
                    begin
                        cause_reg <= kbs_pkg::STOP_LIMIT;
                        state_reg <= S_FINISH;
                    end
                end
                S_SETUP:
                begin
                    zero_sin_reg <= (ang_reg == '0) || (ang_reg == TWO_PI_A);
                    priority if (ang_reg <= HALF_PI_A)
                    begin
                        th_reg <= W'(ang_reg);
                    end
                    else if (ang_reg <= UPPER_A)
                    begin
                        th_reg <= W'(PI_A) - W'(ang_reg);
                    end
                    else
                    begin
                        th_reg <= W'(ang_reg) - W'(TWO_PI_A);
                    end
                    x_reg     <= X0;
                    y_reg     <= '0;
                    it_reg    <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (th_reg >= 0)
                    begin
                        x_reg  <= x_reg - ys;
                        y_reg  <= y_reg + xs;
                        th_reg <= th_reg - atan_tab[it_reg];
                    end
                    else
                    begin
                        x_reg  <= x_reg + ys;
                        y_reg  <= y_reg - xs;
                        th_reg <= th_reg + atan_tab[it_reg];
                    end
                    if (it_reg == LAST_IT)
                    begin
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        it_reg <= it_reg + IW'(1);
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= MGW'(prod_full >> 31);
                    neg_reg   <= !zero_sin_reg && (y_reg < 0);
                    state_reg <= S_FVAL;
                end
                S_FVAL:
                begin
                    unique case (ev_reg)
                        EV_MID:
                        begin
                            if (f_zero)
                            begin
                                exact_reg <= 1'b1;
                                cause_reg <= kbs_pkg::STOP_EXACT;
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                sf_neg_reg <= f_neg;
                                ang_reg    <= lo_reg;
                                ev_reg     <= EV_LO;
                                state_reg  <= S_SETUP;
                            end
                        end
                        EV_LO:
                        begin
                            sa_neg_reg  <= f_neg;
                            sa_zero_reg <= f_zero;
                            ang_reg     <= hi_reg;
                            ev_reg      <= EV_HI;
                            state_reg   <= S_SETUP;
                        end
                        default:
                        begin
                            if (!sa_zero_reg && !f_zero && (sa_neg_reg != f_neg))
                            begin
                                saved_reg      <= mid_reg;
                                have_saved_reg <= 1'b1;
                            end
                            lo_reg <= lo_next;
                            hi_reg <= hi_next;
                            if (32'(width_next) < 32'({tol_reg, 1'b0}))
                            begin
                                cause_reg <= kbs_pkg::STOP_TOL;
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                state_reg <= S_STEP;
                            end
                        end
                    endcase
                end
                default:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg                  <= 1'b1;
                        out_data_reg.eccentric_anomaly <= result[30:0];
                        out_data_reg.stop_cause        <= cause_fin;
                        out_data_reg.steps_used        <= steps_reg;
                        state_reg                      <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

[tb/kbs_checker.sv]
module kbs_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  kbs_pkg::req_t in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  kbs_pkg::rsp_t out_data,
    input  logic          cfg_write,
    input  logic [1:0]    cfg_index,
    input  logic [28:0]   cfg_data,
    output int            errors,
    output int            pending,
    output int            requests_taken
);

    localparam logic [63:0] PI_ANG   = kbs_pkg::PI_Q60 >> 32;
    localparam logic [63:0] HALF_ANG = kbs_pkg::PI_Q60 >> 33;
    localparam logic [63:0] TWO_ANG  = kbs_pkg::PI_Q60 >> 31;

    logic [6:0]     iter_limit;
    logic [28:0]    tol_width;
    logic [63:0]    arctan_steps [30];
    kbs_pkg::rsp_t  solved_q [$];

    function automatic logic [63:0] arctan_q62(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          sh;
        acc = '0;
        if (i == 0)
        begin
            return kbs_pkg::PI_Q60;
        end
        for (int k = 0; k < 64; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh > 62)
            begin
                break;
            end
            term = (64'd1 << (62 - sh)) / 64'(2 * k + 1);
            if (k % 2 == 1)
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    function automatic longint sine_of(input logic [63:0] ang);
        logic [63:0] z;
        longint      th;
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        longint      step;
        z = ang % TWO_ANG;
        if (z == 0)
        begin
            return 0;
        end
        if (z <= HALF_ANG)
        begin
            th = longint'(z);
        end
        else if (z <= PI_ANG + HALF_ANG)
        begin
            th = longint'(PI_ANG) - longint'(z);
        end
        else
        begin
            th = longint'(z) - longint'(TWO_ANG);
        end
        x = longint'(kbs_pkg::GAIN_Q40 >> 12);
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            step = longint'(arctan_steps[i] >> 34);
            xs = x >>> i;
            ys = y >>> i;
            if (th >= 0)
            begin
                x = x - ys;
                y = y + xs;
                th = th - step;
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                th = th + step;
            end
        end
        return y;
    endfunction

    function automatic int kepler_sign(input logic [63:0] ea, input logic [63:0] ma,
                                       input logic [63:0] ecc);
        longint      s;
        logic [63:0] mag;
        logic [63:0] hi_p;
        logic [63:0] lo_p;
        logic [63:0] prod;
        longint      p;
        longint      f;
        s = sine_of(ea);
        mag = (s < 0) ? 64'(-s) : 64'(s);
        hi_p = ecc * (mag >> 20);
        lo_p = ecc * (mag & 64'hFFFFF);
        prod = (hi_p + (lo_p >> 20)) >> 11;
        p = (s < 0) ? -longint'(prod) : longint'(prod);
        f = longint'(ea) - p - longint'(ma);
        return (f > 0) ? 1 : ((f < 0) ? -1 : 0);
    endfunction

    function automatic kbs_pkg::rsp_t solve_kepler(input kbs_pkg::req_t rq,
                                                   input logic [6:0] lim_reg,
                                                   input logic [28:0] tol);
        logic [63:0]   ma;
        logic [63:0]   ecc;
        logic [63:0]   lo;
        logic [63:0]   hi;
        logic [63:0]   mid;
        logic [63:0]   saved;
        logic [63:0]   answer;
        int            lim;
        int            steps;
        int            sf;
        int            sa;
        int            sb;
        bit            have_saved;
        bit            done;
        logic [1:0]    cause;
        kbs_pkg::rsp_t r;
        ma = 64'(rq.mean_anomaly);
        ecc = 64'(rq.eccentricity);
        if (ma > TWO_ANG)
        begin
            ma = TWO_ANG;
        end
        lim = (lim_reg > kbs_pkg::STEP_CAP) ? int'(kbs_pkg::STEP_CAP) : int'(lim_reg);
        lo = '0;
        hi = TWO_ANG;
        answer = '0;
        saved = '0;
        steps = 0;
        cause = kbs_pkg::STOP_LIMIT;
        have_saved = 1'b0;
        done = 1'b0;
        while (steps < lim)
        begin
            mid = (lo + hi) >> 1;
            steps++;
            sf = kepler_sign(mid, ma, ecc);
            if (sf == 0)
            begin
                answer = mid;
                cause = kbs_pkg::STOP_EXACT;
                done = 1'b1;
                break;
            end
            sa = kepler_sign(lo, ma, ecc);
            sb = kepler_sign(hi, ma, ecc);
            if (sa * sb < 0)
            begin
                saved = mid;
                have_saved = 1'b1;
            end
            if (sa * sf < 0)
            begin
                hi = mid;
            end
            else
            begin
                lo = mid;
            end
            if (hi - lo < 2 * 64'(tol))
            begin
                cause = kbs_pkg::STOP_TOL;
                break;
            end
        end
        if (!done)
        begin
            if (have_saved)
            begin
                answer = saved;
            end
            else if (ma == 0)
            begin
                answer = '0;
                cause = kbs_pkg::STOP_EXACT;
            end
            else if (ma == TWO_ANG)
            begin
                answer = TWO_ANG;
                cause = kbs_pkg::STOP_EXACT;
            end
            else
            begin
                answer = TWO_ANG >> 1;
                cause = kbs_pkg::STOP_LIMIT;
            end
        end
        r.eccentric_anomaly = answer[30:0];
        r.stop_cause = cause;
        r.steps_used = 7'(steps);
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < 30; i++)
        begin
            arctan_steps[i] = arctan_q62(i);
        end
    end

    always @(posedge clk)
    begin
        kbs_pkg::rsp_t want;
        if (!rst_n)
        begin
            errors = 0;
            pending = 0;
            requests_taken = 0;
            iter_limit = kbs_pkg::MAX_ITER_RST;
            tol_width = kbs_pkg::TOLERANCE_RST;
            solved_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == kbs_pkg::CFG_MAX_ITER)
                begin
                    iter_limit = cfg_data[6:0];
                end
                else if (cfg_index == kbs_pkg::CFG_TOLERANCE)
                begin
                    tol_width = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                solved_q.insert(solved_q.size(),
                                solve_kepler(in_data, iter_limit, tol_width));
                requests_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (solved_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected result %h", out_data);
                    end
                end
                else
                begin
                    want = solved_q.pop_front();
                    if (want.eccentric_anomaly !== out_data.eccentric_anomaly
                        || want.stop_cause !== out_data.stop_cause
                        || want.steps_used !== out_data.steps_used)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display({"mismatch: expected E=%0d cause=%0d steps=%0d, ",
                                      "got E=%0d cause=%0d steps=%0d"},
                                     want.eccentric_anomaly, want.stop_cause, want.steps_used,
                                     out_data.eccentric_anomaly, out_data.stop_cause,
                                     out_data.steps_used);
                        end
                    end
                end
            end
            pending = solved_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
module tb_top;

    localparam logic [30:0] TWO_PI_ANG = 31'(kbs_pkg::PI_Q60 >> 31);
    localparam int          CYCLE_LIMIT = 20000000;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    kbs_pkg::req_t in_data;
    logic          out_valid;
    logic          out_ready;
    kbs_pkg::rsp_t out_data;
    logic          cfg_write;
    logic [1:0]    cfg_index;
    logic [28:0]   cfg_data;
    int            errors;
    int            pending;
    int            requests_taken;
    int            cycles;
    int            sent;

    kepler_bisection_solver_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kbs_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending),
        .requests_taken (requests_taken)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("kepler_bisection_solver_core regression: fail");
            $finish;
        end
    end

    // receiver: long hold-off window, then a window with no idling
    initial
    begin
        int rx_cycle;
        out_ready = 1'b0;
        rx_cycle = 0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle >= 60000 && rx_cycle < 68000)
            begin
                out_ready = 1'b0;
            end
            else if (rx_cycle >= 150000 && rx_cycle < 250000)
            begin
                out_ready = 1'b1;
            end
            else
            begin
                out_ready = ($urandom_range(0, 99) >= 19);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [28:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
    endtask

    task automatic send_request(input logic [30:0] ma, input logic [30:0] ecc);
        int taken;
        if (!(sent >= 200 && sent < 260) && $urandom_range(0, 99) < 19)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        taken = requests_taken;
        in_valid = 1'b1;
        in_data.mean_anomaly = ma;
        in_data.eccentricity = ecc;
        while (requests_taken == taken)
        begin
            @(negedge clk);
        end
        sent++;
    endtask

    task automatic send_random(input int count);
        logic [30:0] ma;
        logic [30:0] ecc;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                ma = '0;
            end
            else if (pick < 10)
            begin
                ma = TWO_PI_ANG;
            end
            else if (pick < 15)
            begin
                ma = 31'($urandom_range(32'(TWO_PI_ANG), 32'h7FFFFFFF));
            end
            else
            begin
                ma = 31'($urandom_range(0, 32'(TWO_PI_ANG)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                ecc = '0;
            end
            else if (pick < 10)
            begin
                ecc = 31'h7FFFFFFF;
            end
            else
            begin
                ecc = 31'($urandom);
            end
            send_request(ma, ecc);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic run_phase(input logic [28:0] iters, input logic [28:0] tol, input int count);
        drain_results();
        write_reg(kbs_pkg::CFG_MAX_ITER, iters);
        write_reg(kbs_pkg::CFG_TOLERANCE, tol);
        send_random(count);
    endtask

    initial
    begin
        sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = kbs_pkg::CFG_MAX_ITER;
        cfg_data = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(31'd0, 31'd0);
        send_request(31'd0, 31'h7FFFFFFF);
        send_request(TWO_PI_ANG, 31'd0);
        send_request(TWO_PI_ANG, 31'h7FFFFFFF);
        send_request(31'h7FFFFFFF, 31'h40000000);
        send_request(31'h7FFFFFFF, 31'h7FFFFFFF);
        send_request(TWO_PI_ANG >> 1, 31'd0);
        send_request(TWO_PI_ANG >> 2, 31'd0);
        send_request(TWO_PI_ANG >> 1, 31'h7FFFFFFF);
        send_request(31'd1, 31'h7FFFFFFF);
        send_request(TWO_PI_ANG - 31'd1, 31'h7FFFFFFF);
        send_request(31'h55555555, 31'h2AAAAAAA);
        send_request(31'h2AAAAAAA, 31'h55555555);
        send_request(31'h10000000, 31'h00000001);
        in_valid = 1'b0;
        drain_results();
        write_reg(kbs_pkg::CFG_MAX_ITER, 29'd0);
        send_request(31'd0, 31'd5);
        send_request(TWO_PI_ANG, 31'd5);
        send_request(31'h12345678, 31'd5);
        in_valid = 1'b0;

        run_phase(29'd32, 29'd268, 120);
        run_phase(29'd1, 29'd1, 40);
        run_phase(29'd0, 29'd5000, 15);
        run_phase(29'd127, 29'd0, 6);
        run_phase(29'd64, 29'd1, 10);
        run_phase(29'd16, 29'd65536, 150);
        run_phase(29'd8, 29'd268435456, 40);
        run_phase(29'd20, 29'h1FFFFFFF, 30);
        run_phase(29'($urandom_range(2, 14)), 29'($urandom_range(1, 29'h1FFFFFFF)), 120);

        drain_results();
        repeat (200) @(negedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("kepler_bisection_solver_core regression: pass");
        end
        else
        begin
            $display("kepler_bisection_solver_core regression: fail");
        end
        $finish;
    end

endmodule
